FILE: src/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Expects i_clk and i_rst_n (synchronous, active low) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define ASSERT_AT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Implication: when ante holds, cons holds in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    `ASSERT_AT(lbl, (ante) |-> (cons), msg)

`endif

FILE: src/hsd_pkg.sv
// Types, constants and code table for the (7,4) soft ML decoder.
// No dependencies; imported by every decoder module.
package hsd_pkg;

    localparam int NUM_CAND = 16;
    localparam int REL_W    = 16;
    localparam int METRIC_W = 33;
    // metric is split into low and high halves for the multiply in two partial products
    localparam int MLO_W    = 17;
    localparam int MHI_W    = METRIC_W - MLO_W;

    localparam logic [METRIC_W-1:0] METRIC_ONE = 33'h1_0000_0000;
    localparam logic [2:0]          LAST_POS   = 3'd6;
    localparam logic [3:0]          LAST_SCAN  = 4'd15;

    typedef struct packed {
        logic             hard_bit;
        logic [REL_W-1:0] reliability;
    } t_in_item;

    typedef struct packed {
        logic [3:0]          decoded_data;
        logic [METRIC_W-1:0] best_metric;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_HOLD,
        S_SCAN
    } t_state;

    // control broadcast to the row of metric cells
    typedef struct packed {
        logic       mul_lo;
        logic       mul_hi;
        logic       shift;
        logic       hard;
        logic [2:0] pos;
    } t_cell_ctl;

    // control for the argmax stage at the head of the row
    typedef struct packed {
        logic       step;
        logic       first;
        logic       last;
        logic [3:0] idx;
    } t_pick_ctl;

    // code bit at position pos of the codeword for data nibble j (d0 = MSB)
    function automatic logic cand_bit(input logic [3:0] j, input logic [2:0] pos);
        logic d0, d1, d2, d3;
        logic b;
        d0 = j[3];
        d1 = j[2];
        d2 = j[1];
        d3 = j[0];
        case (pos)
            3'd0:    b = d0;
            3'd1:    b = d1;
            3'd2:    b = d2;
            3'd3:    b = d3;
            3'd4:    b = d0 ^ d1 ^ d2;
            3'd5:    b = d1 ^ d2 ^ d3;
            default: b = d0 ^ d1 ^ d3;
        endcase
        return b;
    endfunction

endpackage

FILE: src/hsd_cell.sv
// One metric cell of the decoder row: holds one candidate's metric.
// Depends on hsd_pkg. Multiplies by the bit weight in two partial products, shifts in scan.
module hsd_cell
    import hsd_pkg::*;
#(
    parameter int RB  = 16,
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [RB:0]         i_w_hit,
    input  logic [RB:0]         i_w_miss,
    input  logic [METRIC_W-1:0] i_shift_in,
    output logic [METRIC_W-1:0] o_metric
);

    localparam int WW  = RB + 1;
    localparam int PLW = MLO_W + WW;
    localparam int PHW = MHI_W + WW;
    localparam int SW  = METRIC_W + 1 + WW;

    logic [METRIC_W-1:0] r_metric;
    logic [PLW-1:0]      r_plo;
    logic [WW-1:0]       w;
    logic [PLW-1:0]      n_plo;
    logic [PHW-1:0]      phi;
    logic [SW-1:0]       sum;
    logic [METRIC_W-1:0] n_metric;

    // weight: r on a match with the hard bit, complement otherwise
    assign w = (cand_bit(4'(IDX), i_ctl.pos) == i_ctl.hard) ? i_w_hit : i_w_miss;

    // low partial product is registered on mul_lo, high one plus sum on mul_hi
    assign n_plo    = PLW'(r_metric[MLO_W-1:0]) * PLW'(w);
    assign phi      = PHW'(r_metric[METRIC_W-1:MLO_W]) * PHW'(w);
    assign sum      = (SW'(phi) << MLO_W) + SW'(r_plo);
    assign n_metric = sum[RB+METRIC_W-1:RB];

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_lo) begin
            r_plo <= n_plo;
        end
    end

    // metric register: scan shift refills with 1.0 from the tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= METRIC_ONE;
        end else if (i_ctl.shift) begin
            r_metric <= i_shift_in;
        end else if (i_ctl.mul_hi) begin
            r_metric <= n_metric;
        end
    end

    assign o_metric = r_metric;

endmodule

FILE: src/hsd_pick.sv
// Argmax at the head of the cell row and the result output register.
// Depends on hsd_pkg. Tie keeps the earlier (lower) candidate index.
module hsd_pick
    import hsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pick_ctl           i_ctl,
    input  logic [METRIC_W-1:0] i_metric,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_item
);

    logic [METRIC_W-1:0] r_best_m;
    logic [3:0]          r_best_i;
    logic                r_valid;
    t_out_item           r_item;
    logic                take;
    logic [METRIC_W-1:0] best_m;
    logic [3:0]          best_i;

    // strictly greater wins, so the lowest index keeps a tie
    assign take   = i_ctl.first || (i_metric > r_best_m);
    assign best_m = take ? i_metric : r_best_m;
    assign best_i = take ? i_ctl.idx : r_best_i;

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_best_m <= best_m;
            r_best_i <= best_i;
        end
    end

    // output register, loaded on the last scan step
    always_ff @(posedge i_clk) begin
        if (i_ctl.step && i_ctl.last) begin
            r_item.decoded_data <= best_i;
            r_item.best_metric  <= best_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.step && i_ctl.last) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

FILE: src/hamming74_soft_ml_decoder_core.sv
// Top level of the (7,4) soft-decision ML decoder: sequencer and cell row.
// Depends on hsd_pkg, hsd_cell, hsd_pick and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one code bit
//   per item: a hard decision and its reliability, in the order d0..d3, p0..p2.
//   Output channel (o_out_valid / i_out_ready / o_out_item) gives one result
//   per seven input items: the decoded nibble and the winning metric.
//   Each item passes through S_MUL0 and S_MUL1 in the row of 16 metric cells
//   (two partial products per cell multiplier); a new item can be taken
//   in S_MUL1 while the current one finishes. After the seventh item the row
//   shifts its metrics through the argmax stage, refilling every cell with 1.0;
//   the result is loaded into the output register at the last scan step.
//   No item is taken during the scan.
//   The result sits in an output register; if the receiver stalls, the next
//   codeword's bits are still accepted, and only its scan waits for the slot.
//   Reset (synchronous, active low) sets all metrics to 1.0 and the bit
//   position to zero, and drops any pending result.
`include "assert_macros.svh"

module hamming74_soft_ml_decoder_core
    import hsd_pkg::*;
#(
    parameter int RELIABILITY_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int RB = RELIABILITY_BITS;
    localparam int WW = RB + 1;
    localparam logic [WW-1:0] W_ONE = WW'(1) << RB;

    t_state     r_state, n_state;
    logic [2:0] r_pos;
    logic [3:0] r_scan;
    logic       r_hard;
    logic [WW-1:0] r_w_hit;
    logic [WW-1:0] r_w_miss;
    logic [RB-1:0] rel;
    logic       accept;
    logic       last_bit;
    logic       slot_free;
    t_cell_ctl  cell_ctl;
    t_pick_ctl  pick_ctl;
    logic [METRIC_W-1:0] m_chain [NUM_CAND+1];

    // only the low RB bits of the reliability count
    assign rel      = RB'(i_in_item.reliability);
    assign accept   = i_in_valid && o_in_ready;
    assign last_bit = (r_pos >= LAST_POS);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_in_ready = !last_bit;
                if (last_bit) begin
                    n_state = S_HOLD;
                end else if (accept) begin
                    n_state = S_MUL0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan == LAST_SCAN) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // item capture: hard bit and both weights
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hard   <= i_in_item.hard_bit;
            r_w_hit  <= WW'(rel);
            r_w_miss <= W_ONE - WW'(rel);
        end
    end

    // bit position and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_scan <= '0;
        end else begin
            if (r_state == S_MUL1 && !last_bit) begin
                r_pos <= r_pos + 3'd1;
            end else if (r_state == S_SCAN && r_scan == LAST_SCAN) begin
                r_pos <= '0;
            end
            if (r_state == S_SCAN) begin
                r_scan <= r_scan + 4'd1;
            end else begin
                r_scan <= '0;
            end
        end
    end

    always_comb begin
        cell_ctl.mul_lo = (r_state == S_MUL0);
        cell_ctl.mul_hi = (r_state == S_MUL1);
        cell_ctl.shift  = (r_state == S_SCAN);
        cell_ctl.hard   = r_hard;
        cell_ctl.pos    = r_pos;
        pick_ctl.step   = (r_state == S_SCAN);
        pick_ctl.first  = (r_scan == '0);
        pick_ctl.last   = (r_scan == LAST_SCAN);
        pick_ctl.idx    = r_scan;
    end

    // row of metric cells; the tail shifts in 1.0
    assign m_chain[NUM_CAND] = METRIC_ONE;

    for (genvar k = 0; k < NUM_CAND; k++) begin : g_cell
        hsd_cell #(
            .RB  (RB),
            .IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_w_hit    (r_w_hit),
            .i_w_miss   (r_w_miss),
            .i_shift_in (m_chain[k+1]),
            .o_metric   (m_chain[k])
        );
    end

    hsd_pick u_pick (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (pick_ctl),
        .i_metric    (m_chain[0]),
        .o_free      (slot_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // checks
    `ASSERT_AT(a_scan_to_result, (r_state == S_SCAN && r_scan == 4'd0) |-> ##16 o_out_valid, "result not valid 16 cycles after scan start")
    `ASSERT_IMPL(a_metric_bound, o_out_valid, o_out_item.best_metric <= METRIC_ONE, "best metric above 1.0")
    `ASSERT_IMPL(a_pos_range, 1'b1, r_pos <= LAST_POS, "bit position out of range")
    `ASSERT_IMPL(a_scan_idle_in, r_state == S_SCAN || r_state == S_HOLD, r_pos == LAST_POS, "scan without seventh bit")

endmodule
